[src/des_pkg.sv]
// ============================================================================
// des_pkg: shared types and helpers for the directory entry sorter
// Request/result structs, stored entry layout, controller states and the
// sort key derivation.
// ============================================================================
package des_pkg;

    localparam int ENTRY_COUNT_MAX_DEF = 64;
    localparam int NAME_W              = 64;
    localparam int KEY_W               = 2 * NAME_W + 1;

    typedef struct packed {
        logic [NAME_W-1:0] name_high;
        logic [NAME_W-1:0] name_low;
        logic              is_directory;
        logic              last_entry;
    } t_req;

    typedef struct packed {
        logic [NAME_W-1:0] out_name_high;
        logic [NAME_W-1:0] out_name_low;
        logic              out_is_directory;
        logic              overflow;
        logic              last_result;
    } t_res;

    typedef struct packed {
        logic [NAME_W-1:0] name_high;
        logic [NAME_W-1:0] name_low;
        logic              is_directory;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_CAP,
        S_CMP,
        S_PLACE,
        S_EMIT
    } t_state;

    // Key: inverted dir flag on top (directories first), then the name with
    // every byte after the first zero byte forced to zero.
    function automatic logic [KEY_W-1:0] entry_key(input t_entry e);
        logic [2*NAME_W-1:0] v;
        logic [2*NAME_W-1:0] k;
        logic [15:0]         z;
        logic                ended;
        v = {e.name_high, e.name_low};
        k = '0;
        for (int b = 0; b < 16; b++) begin
            z[b] = (v[127-8*b -: 8] == 8'd0);
        end
        for (int b = 0; b < 16; b++) begin
            ended = |(16'(z << (15 - b)));
            k[127-8*b -: 8] = ended ? 8'd0 : v[127-8*b -: 8];
        end
        return {~e.is_directory, k};
    endfunction

endpackage

[src/des_mem.sv]
// ============================================================================
// des_mem: entry store
// One write port, one read port with registered read data.
// ============================================================================
module des_mem #(
    parameter int DEPTH = des_pkg::ENTRY_COUNT_MAX_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  des_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output des_pkg::t_entry  o_rdata
);
    import des_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/des_cmp.sv]
// ============================================================================
// des_cmp: ordering comparator
// Flags that the earlier entry must move behind the held entry.
// ============================================================================
module des_cmp (
    input  des_pkg::t_entry i_prev,
    input  des_pkg::t_entry i_cur,
    output logic            o_after
);
    import des_pkg::*;

    // strict greater-than keeps equal keys in load order
    assign o_after = entry_key(i_prev) > entry_key(i_cur);

endmodule

[src/directory_entry_sorter.sv]
// ============================================================================
// directory_entry_sorter: stable sort of directory entries
// Loads entries, then emits them directories first, names ascending.
// ============================================================================
// Usage:
//   A request is taken on a clock edge with start high and busy low; one
//   entry loads per cycle while busy stays low. Loads past ENTRY_COUNT_MAX
//   are dropped and the set is marked overflowed.
//   The request with last_entry set (stored or dropped) starts the sort and
//   busy rises. The sort is an insertion sort in the entry RAM using one
//   comparator, one RAM write port and one RAM read port: entry i is read,
//   captured and compared, with one more compare-and-shift step per
//   position it moves; a single entry skips the sort.
//   Emission then reads one entry per cycle; results appear with o_valid for
//   one cycle each, n back to back, each in the cycle after its read, the last
//   with last_result set. busy drops together with the final strobe.
//   The receiver cannot hold results off.
//   Reset (synchronous, active low) empties the set and returns to idle; the
//   RAM contents are not cleared and need no clearing pass.
// ============================================================================
module directory_entry_sorter #(
    parameter int ENTRY_COUNT_MAX = des_pkg::ENTRY_COUNT_MAX_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  des_pkg::t_req i_req,
    output logic          o_valid,
    output des_pkg::t_res o_res
);
    import des_pkg::*;

    localparam int AW = (ENTRY_COUNT_MAX > 1) ? $clog2(ENTRY_COUNT_MAX) : 1;
    localparam int CW = $clog2(ENTRY_COUNT_MAX + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(ENTRY_COUNT_MAX);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    t_entry        r_cur, n_cur;
    logic          r_out_vld, n_out_vld;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          after;

    t_entry        in_entry;
    logic          room;
    logic [CW-1:0] final_cnt;
    logic [CW-1:0] i_inc;

    assign in_entry  = '{name_high:    i_req.name_high,
                         name_low:     i_req.name_low,
                         is_directory: i_req.is_directory};
    assign room      = (r_cnt < CNT_MAX);
    assign final_cnt = room ? r_cnt + CW'(1) : r_cnt;
    assign i_inc     = r_i + CW'(1);

    des_mem #(
        .DEPTH (ENTRY_COUNT_MAX),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    des_cmp u_cmp (
        .i_prev  (mem_rdata),
        .i_cur   (r_cur),
        .o_after (after)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && i_req.last_entry) begin
                    n_state = (final_cnt > CW'(1)) ? S_CUR_RD : S_EMIT;
                end
            end
            S_CUR_RD:  n_state = S_CUR_CAP;
            S_CUR_CAP: n_state = S_CMP;
            S_CMP: begin
                if (after) begin
                    if (r_j == CW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = (i_inc == r_cnt) ? S_EMIT : S_CUR_RD;
                end
            end
            S_PLACE: n_state = (i_inc == r_cnt) ? S_EMIT : S_CUR_RD;
            S_EMIT: begin
                if (r_k == r_cnt - CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_cur      = r_cur;
        n_out_vld  = 1'b0;
        n_out_last = 1'b0;
        n_out_ovf  = r_out_ovf;
        mem_we     = 1'b0;
        mem_waddr  = r_cnt[AW-1:0];
        mem_wdata  = in_entry;
        mem_raddr  = r_i[AW-1:0];
        case (r_state)
            S_IDLE: begin
                n_i = CW'(1);
                n_k = '0;
                if (start) begin
                    if (room) begin
                        mem_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_CUR_RD: begin
                mem_raddr = r_i[AW-1:0];
            end
            S_CUR_CAP: begin
                n_cur     = mem_rdata;
                n_j       = r_i;
                mem_raddr = AW'(r_i - CW'(1));
            end
            S_CMP: begin
                // prefetch the next lower slot in case this one shifts up
                mem_raddr = AW'(r_j - CW'(2));
                mem_we    = 1'b1;
                mem_waddr = r_j[AW-1:0];
                if (after) begin
                    mem_wdata = mem_rdata;
                    n_j       = r_j - CW'(1);
                end else begin
                    mem_wdata = r_cur;
                    n_i       = i_inc;
                end
            end
            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_cur;
                n_i       = i_inc;
            end
            S_EMIT: begin
                mem_raddr  = r_k[AW-1:0];
                n_out_vld  = 1'b1;
                n_out_ovf  = r_ovf;
                n_out_last = (r_k == r_cnt - CW'(1));
                n_k        = r_k + CW'(1);
                if (r_k == r_cnt - CW'(1)) begin
                    n_cnt = '0;
                    n_ovf = 1'b0;
                end
            end
            default: begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
            r_out_vld  <= n_out_vld;
            r_out_last <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_cur     <= n_cur;
        r_out_ovf <= n_out_ovf;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_res   = '{out_name_high:    mem_rdata.name_high,
                       out_name_low:     mem_rdata.name_low,
                       out_is_directory: mem_rdata.is_directory,
                       overflow:         r_out_ovf,
                       last_result:      r_out_last};

    // a burst only follows a sort run
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a preceding sort run");

    // results of one burst come back to back
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last_result |=> o_valid)
        else $error("gap inside result burst");

    // the closing request always starts a run
    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.last_entry |=> busy)
        else $error("last entry did not start a sort");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("entry count beyond capacity");

endmodule
